// File: src/dpsr_pkg.sv
// Shared constants, command codes and unit status type of the dual PWM speed ramp.
// Used by the channel interfaces, the serial units and the top level.
package dpsr_pkg;

  localparam int MOTOR_COUNT = 2;
  localparam int MIDX_W      = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int NOUT        = (MOTOR_COUNT > 1) ? 2 : 1;

  localparam int FUNC_W  = 2;
  localparam int TGT_W   = 8;
  localparam int DUR_W   = 16;
  localparam int SPEED_W = 7;
  localparam int LEVEL_W = 16;
  localparam int DELTA_W = 8;
  localparam int STEP_W  = 13;

  localparam int unsigned FULL_SPEED = 100;
  localparam int unsigned WRAP_RESET = 5000;
  localparam int unsigned TICK_MS    = 10;

  // serial shift-add multiplier: wide operand times a speed-sized digit string
  localparam int MUL_AW = 16;
  localparam int MUL_BW = SPEED_W;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int MUL_CW = $clog2(MUL_BW + 1);

  // serial restoring divider, one quotient bit per cycle
  localparam int DIV_NW = MUL_PW;
  localparam int DIV_DW = 16;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  typedef enum logic [FUNC_W-1:0] {
    FN_SET  = 2'd0,
    FN_RAMP = 2'd1,
    FN_TICK = 2'd2,
    FN_NOP  = 2'd3
  } func_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// File: src/dpsr_if.sv
// Valid/ready channel interfaces for commands in and status results out.
// Depends on dpsr_pkg for the field widths.
interface dpsr_in_if;
  logic                         valid;
  logic                         ready;
  logic [dpsr_pkg::FUNC_W-1:0]  func;
  logic                         motor_sel;
  logic [dpsr_pkg::TGT_W-1:0]   target;
  logic [dpsr_pkg::DUR_W-1:0]   ramp_ms;

  modport source (output valid, func, motor_sel, target, ramp_ms, input ready);
  modport sink   (input valid, func, motor_sel, target, ramp_ms, output ready);
endinterface

interface dpsr_out_if;
  logic                         valid;
  logic                         ready;
  logic [dpsr_pkg::SPEED_W-1:0] speed_a;
  logic [dpsr_pkg::SPEED_W-1:0] speed_b;
  logic [dpsr_pkg::LEVEL_W-1:0] level_a;
  logic [dpsr_pkg::LEVEL_W-1:0] level_b;
  logic                         running;
  logic                         ramping_a;
  logic                         ramping_b;

  modport source (output valid, speed_a, speed_b, level_a, level_b, running,
                  ramping_a, ramping_b, input ready);
  modport sink   (input valid, speed_a, speed_b, level_a, level_b, running,
                  ramping_a, ramping_b, output ready);
endinterface

// File: src/dpsr_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// Depends on dpsr_pkg.
module dpsr_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dpsr_pkg::MUL_AW-1:0] a,
  input  logic [dpsr_pkg::MUL_BW-1:0] b,
  output logic [dpsr_pkg::MUL_PW-1:0] product,
  output dpsr_pkg::unit_stat_t       stat
);
  import dpsr_pkg::*;

  logic [MUL_PW-1:0] acc_r, acc_nxt;
  logic [MUL_AW-1:0] mc_r;
  logic [MUL_BW-1:0] mp_r;
  logic [MUL_CW-1:0] cnt_r;
  logic              busy_r, done_r;

  // double the partial sum and add the multiplicand for the current digit
  assign acc_nxt = {acc_r[MUL_PW-2:0], 1'b0} +
                   (mp_r[MUL_BW-1] ? MUL_PW'(mc_r) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= MUL_CW'(MUL_BW);
        acc_r  <= '0;
        mc_r   <= a;
        mp_r   <= b;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        mp_r  <= {mp_r[MUL_BW-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == MUL_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign product   = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: src/dpsr_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on dpsr_pkg. Divisor must be nonzero.
module dpsr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dpsr_pkg::DIV_NW-1:0] dividend,
  input  logic [dpsr_pkg::DIV_DW-1:0] divisor,
  output logic [dpsr_pkg::DIV_NW-1:0] quotient,
  output dpsr_pkg::unit_stat_t       stat
);
  import dpsr_pkg::*;

  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_NW-1:0] q_r;
  logic [DIV_DW-1:0] dv_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [DIV_DW:0]   rem_sh;
  logic              ge;

  // bring down the next dividend bit, subtract when it fits
  always_comb begin
    rem_sh  = {rem_r, q_r[DIV_NW-1]};
    ge      = (rem_sh >= {1'b0, dv_r});
    rem_nxt = ge ? DIV_DW'(rem_sh - {1'b0, dv_r}) : rem_sh[DIV_DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CW'(DIV_NW);
        rem_r  <= '0;
        q_r    <= dividend;
        dv_r   <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[DIV_NW-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: src/dual_pwm_speed_ramp.sv
// Dual motor speed controller with linear ramps and PWM level output.
// Depends on dpsr_pkg, dpsr_if, dpsr_mul and dpsr_div.
//
// One command at a time: set speed, start ramp or 10 ms tick; each returns one status
// beat with both speeds, both PWM levels (wrap * speed / 100) and the ramp flags.
// A set or an unused code runs the 7-step serial multiplier and the 23-step serial
// divider that compute the two levels one after the other; a ramp that starts first
// runs the divider once for steps = duration / 10, and a tick visits each motor in
// turn and runs a multiply and a divide for each motor whose ramp is active. The next
// command is taken once the current one has been handed to the output register,
// even while that result still waits; a result that has not been taken when the next
// one is ready holds the block until it goes.
module dual_pwm_speed_ramp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [dpsr_pkg::LEVEL_W-1:0] cfg_wdata,
  dpsr_in_if.sink                     in_ch,
  dpsr_out_if.source                  out_ch
);
  import dpsr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CMD, S_DUR, S_TSEL, S_TMUL, S_TDIV, S_LMUL, S_LDIV, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [LEVEL_W-1:0] wrap_r, wrap_nxt;

  // per-motor state
  logic [SPEED_W-1:0] speed_now_r   [MOTOR_COUNT];
  logic [SPEED_W-1:0] speed_now_nxt [MOTOR_COUNT];
  logic [SPEED_W-1:0] origin_r      [MOTOR_COUNT];
  logic [SPEED_W-1:0] origin_nxt    [MOTOR_COUNT];
  logic [DELTA_W-1:0] delta_r       [MOTOR_COUNT];
  logic [DELTA_W-1:0] delta_nxt     [MOTOR_COUNT];
  logic [STEP_W-1:0]  total_r       [MOTOR_COUNT];
  logic [STEP_W-1:0]  total_nxt     [MOTOR_COUNT];
  logic [STEP_W-1:0]  count_r       [MOTOR_COUNT];
  logic [STEP_W-1:0]  count_nxt     [MOTOR_COUNT];
  logic               ramp_on_r     [MOTOR_COUNT];
  logic               ramp_on_nxt   [MOTOR_COUNT];

  // latched command
  func_t              func_r, func_nxt;
  logic               sel_ok_r, sel_ok_nxt;
  logic [SPEED_W-1:0] tgt_r, tgt_nxt;
  logic [DUR_W-1:0]   dur_r, dur_nxt;
  logic [MIDX_W-1:0]  midx_r, midx_nxt;
  logic               lvl_idx_r, lvl_idx_nxt;
  logic [LEVEL_W-1:0] lvl_r   [NOUT];
  logic [LEVEL_W-1:0] lvl_nxt [NOUT];

  // unit operands
  logic               mul_start_r, mul_start_nxt;
  logic [MUL_AW-1:0]  mul_a_r, mul_a_nxt;
  logic [MUL_BW-1:0]  mul_b_r, mul_b_nxt;
  logic               div_start_r, div_start_nxt;
  logic [DIV_NW-1:0]  div_nd_r, div_nd_nxt;
  logic [DIV_DW-1:0]  div_dv_r, div_dv_nxt;

  logic [MUL_PW-1:0]  mul_prod;
  logic [DIV_NW-1:0]  div_quot;
  unit_stat_t         mul_stat, div_stat;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [SPEED_W-1:0] o_speed_a_r, o_speed_a_nxt, o_speed_b_r, o_speed_b_nxt;
  logic [LEVEL_W-1:0] o_level_a_r, o_level_a_nxt, o_level_b_r, o_level_b_nxt;
  logic               o_run_r, o_run_nxt, o_ramp_a_r, o_ramp_a_nxt, o_ramp_b_r, o_ramp_b_nxt;

  // current motor view, one read address
  logic [SPEED_W-1:0] cur_speed, cur_origin, cur_mag, cur_q;
  logic [DELTA_W-1:0] cur_delta;
  logic [STEP_W-1:0]  cur_total, cnt_new;
  logic [SPEED_W+1:0] sum_w;
  logic [SPEED_W-1:0] step_speed;
  logic [STEP_W-1:0]  steps_q;
  logic               any_run;
  logic               last_motor;

  assign cur_speed  = speed_now_r[midx_r];
  assign cur_origin = origin_r[midx_r];
  assign cur_delta  = delta_r[midx_r];
  assign cur_total  = total_r[midx_r];
  assign cnt_new    = count_r[midx_r] + 1'b1;
  assign cur_mag    = cur_delta[DELTA_W-1] ? SPEED_W'(~cur_delta + 1'b1)
                                           : cur_delta[SPEED_W-1:0];
  assign cur_q      = div_quot[SPEED_W-1:0];
  assign last_motor = (midx_r == MIDX_W'(MOTOR_COUNT - 1));
  assign steps_q    = (div_quot[STEP_W-1:0] == '0) ? STEP_W'(1) : div_quot[STEP_W-1:0];

  // origin plus or minus the scaled step, clamped to 0..100
  always_comb begin
    sum_w = cur_delta[DELTA_W-1] ? ({2'b0, cur_origin} - {2'b0, cur_q})
                                 : ({2'b0, cur_origin} + {2'b0, cur_q});
    if (sum_w[SPEED_W+1]) begin
      step_speed = '0;
    end else if (sum_w > (SPEED_W+2)'(FULL_SPEED)) begin
      step_speed = SPEED_W'(FULL_SPEED);
    end else begin
      step_speed = sum_w[SPEED_W-1:0];
    end
  end

  always_comb begin
    any_run = 1'b0;
    for (int k = 0; k < MOTOR_COUNT; k++) begin
      any_run = any_run | (speed_now_r[k] != '0);
    end
  end

  dpsr_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start_r),
    .a       (mul_a_r),
    .b       (mul_b_r),
    .product (mul_prod),
    .stat    (mul_stat)
  );

  dpsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_nd_r),
    .divisor  (div_dv_r),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    wrap_nxt      = cfg_we ? cfg_wdata : wrap_r;
    speed_now_nxt = speed_now_r;
    origin_nxt    = origin_r;
    delta_nxt     = delta_r;
    total_nxt     = total_r;
    count_nxt     = count_r;
    ramp_on_nxt   = ramp_on_r;
    func_nxt      = func_r;
    sel_ok_nxt    = sel_ok_r;
    tgt_nxt       = tgt_r;
    dur_nxt       = dur_r;
    midx_nxt      = midx_r;
    lvl_idx_nxt   = lvl_idx_r;
    lvl_nxt       = lvl_r;
    mul_start_nxt = 1'b0;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    div_start_nxt = 1'b0;
    div_nd_nxt    = div_nd_r;
    div_dv_nxt    = div_dv_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    o_speed_a_nxt = o_speed_a_r;
    o_speed_b_nxt = o_speed_b_r;
    o_level_a_nxt = o_level_a_r;
    o_level_b_nxt = o_level_b_r;
    o_run_nxt     = o_run_r;
    o_ramp_a_nxt  = o_ramp_a_r;
    o_ramp_b_nxt  = o_ramp_b_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          func_nxt   = func_t'(in_ch.func);
          sel_ok_nxt = (32'(in_ch.motor_sel) < MOTOR_COUNT);
          midx_nxt   = MIDX_W'(in_ch.motor_sel);
          tgt_nxt    = (in_ch.target > TGT_W'(FULL_SPEED)) ? SPEED_W'(FULL_SPEED)
                                                           : in_ch.target[SPEED_W-1:0];
          dur_nxt    = in_ch.ramp_ms;
          state_nxt  = S_CMD;
        end
      end
      S_CMD: begin
        state_nxt = S_LMUL;
        unique case (func_r)
          FN_SET: begin
            if (sel_ok_r) begin
              speed_now_nxt[midx_r] = tgt_r;
              ramp_on_nxt[midx_r]   = 1'b0;
            end
          end
          FN_RAMP: begin
            if (sel_ok_r) begin
              if (tgt_r == cur_speed || dur_r == '0) begin
                speed_now_nxt[midx_r] = tgt_r;
                ramp_on_nxt[midx_r]   = 1'b0;
              end else begin
                origin_nxt[midx_r]  = cur_speed;
                delta_nxt[midx_r]   = DELTA_W'({1'b0, tgt_r}) - DELTA_W'({1'b0, cur_speed});
                count_nxt[midx_r]   = '0;
                ramp_on_nxt[midx_r] = 1'b1;
                div_start_nxt       = 1'b1;
                div_nd_nxt          = DIV_NW'(dur_r);
                div_dv_nxt          = DIV_DW'(TICK_MS);
                state_nxt           = S_DUR;
              end
            end
          end
          FN_TICK: begin
            midx_nxt  = '0;
            state_nxt = S_TSEL;
          end
          default: begin
          end
        endcase
      end
      S_DUR: begin
        if (div_stat.done) begin
          total_nxt[midx_r] = steps_q;
          state_nxt         = S_LMUL;
        end
      end
      S_TSEL: begin
        if (ramp_on_r[midx_r]) begin
          count_nxt[midx_r] = cnt_new;
          mul_start_nxt     = 1'b1;
          mul_a_nxt         = MUL_AW'(cnt_new);
          mul_b_nxt         = cur_mag;
          state_nxt         = S_TMUL;
        end else if (last_motor) begin
          state_nxt = S_LMUL;
        end else begin
          midx_nxt = midx_r + 1'b1;
        end
      end
      S_TMUL: begin
        if (mul_stat.done) begin
          div_start_nxt = 1'b1;
          div_nd_nxt    = DIV_NW'(mul_prod);
          div_dv_nxt    = DIV_DW'(cur_total);
          state_nxt     = S_TDIV;
        end
      end
      S_TDIV: begin
        if (div_stat.done) begin
          speed_now_nxt[midx_r] = step_speed;
          if (count_r[midx_r] >= cur_total) begin
            ramp_on_nxt[midx_r] = 1'b0;
          end
          if (last_motor) begin
            state_nxt = S_LMUL;
          end else begin
            midx_nxt  = midx_r + 1'b1;
            state_nxt = S_TSEL;
          end
        end
      end
      S_LMUL: begin
        // on first entry, with the unit idle, kick the level product of motor 0
        if (!mul_stat.busy && !mul_start_r && lvl_idx_r == 1'b0 && !mul_stat.done) begin
          mul_start_nxt = 1'b1;
          mul_a_nxt     = wrap_r;
          mul_b_nxt     = speed_now_r[0];
          lvl_idx_nxt   = 1'b1;
        end else if (mul_stat.done) begin
          div_start_nxt = 1'b1;
          div_nd_nxt    = mul_prod;
          div_dv_nxt    = DIV_DW'(FULL_SPEED);
          state_nxt     = S_LDIV;
        end
      end
      S_LDIV: begin
        if (div_stat.done) begin
          // lvl_idx_r is set once the motor 0 product is issued: 1 means motor 0 is done
          if (lvl_idx_r && NOUT > 1) begin
            lvl_nxt[0]    = div_quot[LEVEL_W-1:0];
            mul_start_nxt = 1'b1;
            mul_a_nxt     = wrap_r;
            mul_b_nxt     = speed_now_r[NOUT-1];
            lvl_idx_nxt   = 1'b0;
            state_nxt     = S_LMUL;
          end else begin
            lvl_nxt[NOUT-1] = div_quot[LEVEL_W-1:0];
            lvl_idx_nxt     = 1'b0;
            state_nxt       = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_speed_a_nxt = speed_now_r[0];
          o_level_a_nxt = lvl_r[0];
          o_ramp_a_nxt  = ramp_on_r[0];
          o_speed_b_nxt = (NOUT > 1) ? speed_now_r[NOUT-1] : '0;
          o_level_b_nxt = (NOUT > 1) ? lvl_r[NOUT-1] : '0;
          o_ramp_b_nxt  = (NOUT > 1) ? ramp_on_r[NOUT-1] : 1'b0;
          o_run_nxt     = any_run;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wrap_r      <= LEVEL_W'(WRAP_RESET);
      lvl_idx_r   <= 1'b0;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < MOTOR_COUNT; k++) begin
        speed_now_r[k] <= '0;
        origin_r[k]    <= '0;
        delta_r[k]     <= '0;
        total_r[k]     <= '0;
        count_r[k]     <= '0;
        ramp_on_r[k]   <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      wrap_r      <= wrap_nxt;
      lvl_idx_r   <= lvl_idx_nxt;
      mul_start_r <= mul_start_nxt;
      div_start_r <= div_start_nxt;
      out_valid_r <= out_valid_nxt;
      speed_now_r <= speed_now_nxt;
      origin_r    <= origin_nxt;
      delta_r     <= delta_nxt;
      total_r     <= total_nxt;
      count_r     <= count_nxt;
      ramp_on_r   <= ramp_on_nxt;
    end
    func_r      <= func_nxt;
    sel_ok_r    <= sel_ok_nxt;
    tgt_r       <= tgt_nxt;
    dur_r       <= dur_nxt;
    midx_r      <= midx_nxt;
    lvl_r       <= lvl_nxt;
    mul_a_r     <= mul_a_nxt;
    mul_b_r     <= mul_b_nxt;
    div_nd_r    <= div_nd_nxt;
    div_dv_r    <= div_dv_nxt;
    o_speed_a_r <= o_speed_a_nxt;
    o_speed_b_r <= o_speed_b_nxt;
    o_level_a_r <= o_level_a_nxt;
    o_level_b_r <= o_level_b_nxt;
    o_run_r     <= o_run_nxt;
    o_ramp_a_r  <= o_ramp_a_nxt;
    o_ramp_b_r  <= o_ramp_b_nxt;
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.speed_a   = o_speed_a_r;
  assign out_ch.speed_b   = o_speed_b_r;
  assign out_ch.level_a   = o_level_a_r;
  assign out_ch.level_b   = o_level_b_r;
  assign out_ch.running   = o_run_r;
  assign out_ch.ramping_a = o_ramp_a_r;
  assign out_ch.ramping_b = o_ramp_b_r;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for dual_pwm_speed_ramp: random set, ramp and tick traffic
// with idle gaps on both channels. Depends on dpsr_pkg, dpsr_if and the block itself.
module tb_top;
  import dpsr_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_TICKS = 200;

  typedef struct packed {
    func_t                func;
    logic                 motor_sel;
    logic [TGT_W-1:0]     target;
    logic [DUR_W-1:0]     ramp_ms;
  } speed_cmd_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_a;
    logic [SPEED_W-1:0] speed_b;
    logic [LEVEL_W-1:0] level_a;
    logic [LEVEL_W-1:0] level_b;
    logic               running;
    logic               ramping_a;
    logic               ramping_b;
  } motor_status_t;

  class ramp_status_board;
    int unsigned   wrap;
    int unsigned   speed       [MOTOR_COUNT];
    int unsigned   origin      [MOTOR_COUNT];
    int            delta       [MOTOR_COUNT];
    int unsigned   step_total  [MOTOR_COUNT];
    int unsigned   step_count  [MOTOR_COUNT];
    bit            ramp_active [MOTOR_COUNT];
    motor_status_t status_due[$];
    int            errors;

    function new();
      wrap = WRAP_RESET;
      errors = 0;
      foreach (speed[k]) begin
        speed[k] = 0;
        origin[k] = 0;
        delta[k] = 0;
        step_total[k] = 0;
        step_count[k] = 0;
        ramp_active[k] = 1'b0;
      end
    endfunction

    function void set_wrap(logic [LEVEL_W-1:0] value);
      wrap = 32'(value);
    endfunction

    function int pending();
      return status_due.size();
    endfunction

    function logic [LEVEL_W-1:0] level_for(int unsigned spd);
      return LEVEL_W'((wrap & 32'hFFFF) * spd / FULL_SPEED);
    endfunction

    function void advance_ramp(int k);
      int unsigned mag;
      int unsigned q;
      int          nv;
      step_count[k] = (step_count[k] + 1) & 32'h1FFF;
      mag = (delta[k] < 0) ? -delta[k] : delta[k];
      q = (step_total[k] != 0) ? mag * step_count[k] / step_total[k] : mag;
      nv = (delta[k] < 0) ? int'(origin[k]) - int'(q) : int'(origin[k]) + int'(q);
      if (nv < 0) nv = 0;
      if (nv > int'(FULL_SPEED)) nv = FULL_SPEED;
      speed[k] = nv;
      if (step_count[k] >= step_total[k]) ramp_active[k] = 1'b0;
    endfunction

    function void note_command(speed_cmd_t c);
      int unsigned   tgt;
      int unsigned   steps;
      int            m;
      int            d;
      motor_status_t s;
      tgt = (32'(c.target) > FULL_SPEED) ? FULL_SPEED : 32'(c.target);
      m = int'(c.motor_sel);
      case (c.func)
        FN_SET: begin
          if (m < MOTOR_COUNT) begin
            speed[m] = tgt;
            ramp_active[m] = 1'b0;
          end
        end
        FN_RAMP: begin
          if (m < MOTOR_COUNT) begin
            d = int'(tgt) - int'(speed[m]);
            if (d == 0 || c.ramp_ms == 0) begin
              speed[m] = tgt;
              ramp_active[m] = 1'b0;
            end else begin
              steps = 32'(c.ramp_ms) / TICK_MS;
              if (steps == 0) steps = 1;
              origin[m] = speed[m];
              delta[m] = d;
              step_total[m] = steps & 32'h1FFF;
              step_count[m] = 0;
              ramp_active[m] = 1'b1;
            end
          end
        end
        FN_TICK: begin
          for (int k = 0; k < MOTOR_COUNT; k++)
            if (ramp_active[k]) advance_ramp(k);
        end
        default: ;
      endcase

      s = '0;
      s.speed_a = SPEED_W'(speed[0]);
      s.level_a = level_for(speed[0]);
      s.ramping_a = ramp_active[0];
      if (MOTOR_COUNT > 1) begin
        s.speed_b = SPEED_W'(speed[MOTOR_COUNT-1]);
        s.level_b = level_for(speed[MOTOR_COUNT-1]);
        s.ramping_b = ramp_active[MOTOR_COUNT-1];
      end
      for (int k = 0; k < MOTOR_COUNT; k++)
        if (speed[k] > 0) s.running = 1'b1;
      status_due.push_back(s);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_status(motor_status_t got);
      motor_status_t want;
      if (status_due.size() == 0) begin
        $error("status beat with no command outstanding");
        errors++;
        return;
      end
      want = status_due.pop_front();
      compare_field("speed_a", 16'(want.speed_a), 16'(got.speed_a));
      compare_field("speed_b", 16'(want.speed_b), 16'(got.speed_b));
      compare_field("level_a", want.level_a, got.level_a);
      compare_field("level_b", want.level_b, got.level_b);
      compare_field("running", 16'(want.running), 16'(got.running));
      compare_field("ramping_a", 16'(want.ramping_a), 16'(got.ramping_a));
      compare_field("ramping_b", 16'(want.ramping_b), 16'(got.ramping_b));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [LEVEL_W-1:0]  cfg_wdata;
  bit                  no_idle;
  int                  quiet_cycles;
  ramp_status_board    board;

  dpsr_in_if  in_ch();
  dpsr_out_if out_ch();

  dual_pwm_speed_ramp u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // end the run if neither channel moves a beat for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("dual_pwm_speed_ramp regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_command(input speed_cmd_t c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= c.func;
    in_ch.motor_sel <= c.motor_sel;
    in_ch.target    <= c.target;
    in_ch.ramp_ms   <= c.ramp_ms;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_command(c);
  endtask

  task automatic send_fields(input func_t f, input logic sel, input int tgt, input int dur);
    speed_cmd_t c;
    c.func = f;
    c.motor_sel = sel;
    c.target = TGT_W'(tgt);
    c.ramp_ms = DUR_W'(dur);
    send_command(c);
  endtask

  // drop valid and hold until every status beat is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_wrap(input logic [LEVEL_W-1:0] value);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_wrap(value);
  endtask

  task automatic collect_status();
    int            stall;
    motor_status_t got;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.speed_a   = out_ch.speed_a;
      got.speed_b   = out_ch.speed_b;
      got.level_a   = out_ch.level_a;
      got.level_b   = out_ch.level_b;
      got.running   = out_ch.running;
      got.ramping_a = out_ch.ramping_a;
      got.ramping_b = out_ch.ramping_b;
      board.check_status(got);
    end
  endtask

  function automatic speed_cmd_t random_command();
    speed_cmd_t c;
    int         pick;
    pick = $urandom_range(0, 99);
    c.motor_sel = 1'($urandom_range(0, 1));
    c.target = ($urandom_range(0, 7) == 0) ? TGT_W'($urandom_range(0, 255))
                                           : TGT_W'($urandom_range(0, 100));
    c.ramp_ms = DUR_W'($urandom_range(0, 65535));
    if (pick < 45) begin
      c.func = FN_TICK;
    end else if (pick < 75) begin
      c.func = FN_RAMP;
      // mostly short ramps so they run to the end
      pick = $urandom_range(0, 9);
      if (pick < 7) c.ramp_ms = DUR_W'($urandom_range(10, 250));
      else if (pick < 9) c.ramp_ms = DUR_W'($urandom_range(0, 19));
    end else if (pick < 95) begin
      c.func = FN_SET;
    end else begin
      c.func = FN_NOP;
    end
    return c;
  endfunction

  task automatic run_directed();
    send_fields(FN_SET,  1'b0, 0,   0);
    send_fields(FN_SET,  1'b0, 255, 65535);
    send_fields(FN_SET,  1'b1, 100, 0);
    send_fields(FN_SET,  1'b1, 101, 0);
    send_fields(FN_NOP,  1'b1, 255, 65535);
    send_fields(FN_RAMP, 1'b0, 50,  0);
    send_fields(FN_RAMP, 1'b0, 50,  100);
    send_fields(FN_RAMP, 1'b0, 0,   5);
    send_fields(FN_TICK, 1'b0, 0,   0);
    send_fields(FN_RAMP, 1'b1, 0,   30);
    send_fields(FN_TICK, 1'b1, 255, 65535);
    // restart a running ramp from where it stands
    send_fields(FN_RAMP, 1'b1, 100, 40);
    repeat (5) send_fields(FN_TICK, 1'b0, 0, 0);
    send_fields(FN_RAMP, 1'b0, 255, 65535);
    send_fields(FN_TICK, 1'b0, 0,   0);
    send_fields(FN_TICK, 1'b0, 0,   0);
    send_fields(FN_SET,  1'b0, 0,   0);
    send_fields(FN_TICK, 1'b0, 0,   0);
  endtask

  initial begin
    logic [LEVEL_W-1:0] wraps [5];
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.func      = '0;
    in_ch.motor_sel = 1'b0;
    in_ch.target    = '0;
    in_ch.ramp_ms   = '0;
    out_ch.ready    = 1'b0;
    no_idle         = 1'b0;
    board           = new();
    wraps = '{16'd65535, 16'd1, 16'd0, 16'($urandom_range(2, 65534)), 16'd5000};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    fork
      collect_status();
    join_none

    run_directed();
    drain();

    foreach (wraps[p]) begin
      write_wrap(wraps[p]);
      no_idle = (p == 3);
      repeat (96) send_command(random_command());
      drain();
    end
    no_idle = 1'b0;

    repeat (SETTLE_TICKS) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("dual_pwm_speed_ramp regression: pass");
    end else begin
      $display("dual_pwm_speed_ramp regression: fail");
    end
    $finish;
  end

endmodule

// File: dual_pwm_speed_ramp.f
src/dpsr_pkg.sv
src/dpsr_if.sv
src/dpsr_mul.sv
src/dpsr_div.sv
src/dual_pwm_speed_ramp.sv
test/tb_top.sv
